// ===== hw/rtl/qr_alphanumeric_codeword_packer_assert.svh =====
// Assertion macros shared by the packer RTL.
// Each macro expands to one labeled concurrent assertion that is disabled during reset.
`ifndef QR_ALPHANUMERIC_CODEWORD_PACKER_ASSERT_SVH
`define QR_ALPHANUMERIC_CODEWORD_PACKER_ASSERT_SVH

// Same-cycle implication.
`define QRAC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion violated");

// Next-cycle implication.
`define QRAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion violated");

`endif

// ===== hw/rtl/qrac_pkg.sv =====
// ----------------------------------------------------------------------------
// qrac_pkg
// Shared constants, types and the character mapping for the alphanumeric
// codeword packer.
// ----------------------------------------------------------------------------
package qrac_pkg;

    // Symbol size and derived capacities
    localparam int DATA_CODEWORDS = 9;
    localparam int TOTAL_BITS     = 8 * DATA_CODEWORDS;
    localparam int PAYLOAD_BITS   = TOTAL_BITS - 13;
    localparam int CHAR_CAPACITY  = (PAYLOAD_BITS / 11) * 2 + (((PAYLOAD_BITS % 11) >= 6) ? 1 : 0);

    localparam int CAP_W   = $clog2(CHAR_CAPACITY + 1);
    localparam int SENT_W  = $clog2(DATA_CODEWORDS + 1);
    localparam int TOTAL_W = $clog2(TOTAL_BITS + 1);
    localparam int ACC_W   = 24;
    localparam int ABITS_W = 5;
    localparam int NBITS_W = 4;
    localparam int VALUE_W = 13;

    // Op queue depth
    localparam int OPQ_DEPTH = 4;
    localparam int OPQ_AW    = $clog2(OPQ_DEPTH);

    // Command codes
    localparam logic CMD_BEGIN = 1'b0;
    localparam logic CMD_CHAR  = 1'b1;

    // Status codes
    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_INVALID = 2'd1;
    localparam logic [1:0] STATUS_CLAMPED = 2'd2;

    // Fixed field sizes and fill bytes
    localparam logic [NBITS_W-1:0] HEADER_BITS = 4'd13;
    localparam logic [NBITS_W-1:0] PAIR_BITS   = 4'd11;
    localparam logic [NBITS_W-1:0] SINGLE_BITS = 4'd6;
    localparam logic [NBITS_W-1:0] NO_BITS     = 4'd0;
    localparam logic [7:0]         PAD_BYTE_A  = 8'hEC;
    localparam logic [7:0]         PAD_BYTE_B  = 8'h11;
    localparam logic [3:0]         MODE_RESET  = 4'd2;
    localparam logic [10:0]        ALNUM_BASE  = 11'd45;

    // One classified work step for the back end
    typedef struct packed {
        logic                 is_begin;
        logic                 finish;
        logic [1:0]           raise;
        logic [NBITS_W-1:0]   nbits;
        logic [VALUE_W-1:0]   value;
    } t_op;

    // One result item
    typedef struct packed {
        logic [7:0] codeword;
        logic       last;
        logic [1:0] status;
    } t_result;

    // Back-end status seen by the top level
    typedef struct packed {
        logic [SENT_W-1:0] sent;
        logic              finishing;
    } t_back_stat;

    // Map an ASCII code to {valid, index} in the 45-symbol set
    function automatic logic [6:0] sym_index(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        unique case (c) inside
            [8'h30:8'h39]: begin
                d = c - 8'h30;
                sym_index = {1'b1, d[5:0]};
            end
            [8'h41:8'h5A]: begin
                d = c - 8'h37;
                sym_index = {1'b1, d[5:0]};
            end
            8'h20:   sym_index = {1'b1, 6'd36};
            8'h24:   sym_index = {1'b1, 6'd37};
            8'h25:   sym_index = {1'b1, 6'd38};
            8'h2A:   sym_index = {1'b1, 6'd39};
            8'h2B:   sym_index = {1'b1, 6'd40};
            8'h2D:   sym_index = {1'b1, 6'd41};
            8'h2E:   sym_index = {1'b1, 6'd42};
            8'h2F:   sym_index = {1'b1, 6'd43};
            8'h3A:   sym_index = {1'b1, 6'd44};
            default: sym_index = {1'b0, 6'd0};
        endcase
    endfunction

endpackage

// ===== hw/rtl/qrac_front.sv =====
// ----------------------------------------------------------------------------
// qrac_front
// Accepts begin and character items, tracks the message count and pairing,
// and turns each begin or in-message character into a back-end append step.
// ----------------------------------------------------------------------------
module qrac_front
    import qrac_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_cmd,
    input  logic [8:0] i_message_length,
    input  logic [7:0] i_char_code,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_mode_bits,
    input  logic       i_opq_full,
    output logic       o_op_push,
    output t_op        o_op
);

    logic [3:0]       r_mode_bits;
    logic             r_active, n_active;
    logic [CAP_W-1:0] r_remain, n_remain;
    logic             r_hold, n_hold;
    logic [5:0]       r_held_idx, n_held_idx;

    logic             accept;
    logic [6:0]       sym;
    logic [8:0]       len_c;
    logic             clamped;
    logic [10:0]      pair_val;

    assign full        = i_opq_full;
    assign accept      = push && !i_opq_full;
    assign o_cfg_ready = 1'b1;

    // Map the character and clamp the count
    assign sym      = sym_index(i_char_code);
    assign clamped  = i_message_length > 9'(CHAR_CAPACITY);
    assign len_c    = clamped ? 9'(CHAR_CAPACITY) : i_message_length;
    assign pair_val = ({5'd0, r_held_idx} * ALNUM_BASE) + {5'd0, sym[5:0]};

    // Classify the item into one append step
    always_comb begin
        n_active   = r_active;
        n_remain   = r_remain;
        n_hold     = r_hold;
        n_held_idx = r_held_idx;
        o_op_push  = 1'b0;
        o_op       = '0;
        if (accept) begin
            if (i_cmd == CMD_BEGIN) begin
                o_op_push      = 1'b1;
                o_op.is_begin  = 1'b1;
                o_op.finish    = (len_c == 9'd0);
                o_op.raise     = clamped ? STATUS_CLAMPED : STATUS_OK;
                o_op.nbits     = HEADER_BITS;
                o_op.value     = {r_mode_bits, len_c};
                n_active       = (len_c != 9'd0);
                n_remain       = len_c[CAP_W-1:0];
                n_hold         = 1'b0;
            end else if (r_active) begin
                o_op_push  = 1'b1;
                o_op.raise = sym[6] ? STATUS_OK : STATUS_INVALID;
                if (r_hold) begin
                    o_op.nbits = PAIR_BITS;
                    o_op.value = {2'd0, pair_val};
                    n_hold     = 1'b0;
                end else if (r_remain == CAP_W'(1)) begin
                    o_op.nbits = SINGLE_BITS;
                    o_op.value = {7'd0, sym[5:0]};
                end else begin
                    o_op.nbits = NO_BITS;
                    n_hold     = 1'b1;
                    n_held_idx = sym[5:0];
                end
                n_remain = r_remain - 1'b1;
                if (r_remain == CAP_W'(1)) begin
                    o_op.finish = 1'b1;
                    n_active    = 1'b0;
                end
            end
        end
    end

    // Hold configuration and message tracking
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode_bits <= MODE_RESET;
            r_active    <= 1'b0;
            r_remain    <= '0;
            r_hold      <= 1'b0;
            r_held_idx  <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_mode_bits <= i_cfg_mode_bits;
            end
            r_active   <= n_active;
            r_remain   <= n_remain;
            r_hold     <= n_hold;
            r_held_idx <= n_held_idx;
        end
    end

endmodule

// ===== hw/rtl/qrac_op_queue.sv =====
// ----------------------------------------------------------------------------
// qrac_op_queue
// Short queue of append steps between the front and back ends.
// ----------------------------------------------------------------------------
module qrac_op_queue
    import qrac_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    input  logic i_pop,
    output t_op  o_op,
    output logic o_empty
);

    t_op                r_mem [OPQ_DEPTH];
    logic [OPQ_AW-1:0]  r_wptr;
    logic [OPQ_AW-1:0]  r_rptr;
    logic [OPQ_AW:0]    r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == (OPQ_AW+1)'(OPQ_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_op    = r_mem[r_rptr];

    // Store the pushed step
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_op;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (do_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== hw/rtl/qrac_back.sv =====
// ----------------------------------------------------------------------------
// qrac_back
// Bit accumulator that executes append steps, cuts codewords, adds the
// terminator, zero fill and pad bytes, and queues the result items.
// ----------------------------------------------------------------------------
module qrac_back
    import qrac_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_op         i_op,
    input  logic        i_op_empty,
    output logic        o_op_pop,
    output logic        empty,
    input  logic        pop,
    output logic [7:0]  o_codeword,
    output logic        o_last_codeword,
    output logic [1:0]  o_status,
    output t_back_stat  o_stat
);

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_FLUSH = 3'b010,
        ST_PAD   = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [ACC_W-1:0]   r_acc, n_acc;
    logic [ABITS_W-1:0] r_bits, n_bits;
    logic [TOTAL_W-1:0] r_total, n_total;
    logic [SENT_W-1:0]  r_sent, n_sent;
    logic [1:0]         r_status, n_status;
    logic               r_fin, n_fin;
    logic               r_pad, n_pad;

    // Result queue
    t_result            r_rq [2];
    logic               r_rq_wp;
    logic               r_rq_rp;
    logic [1:0]         r_rq_cnt;
    logic               rq_full;
    logic               rq_write;
    logic               rq_read;
    t_result            rq_data;

    logic [ACC_W-1:0]   acc_shift;
    logic [7:0]         byte_hi;
    logic [7:0]         byte_fill;
    logic [SENT_W-1:0]  sent_inc;
    logic               room_left;
    logic               emit_ok;
    logic [TOTAL_W-1:0] room;
    logic [2:0]         term;

    assign rq_full   = (r_rq_cnt == 2'd2);
    assign room_left = (r_sent < SENT_W'(DATA_CODEWORDS));
    assign emit_ok   = !rq_full || !room_left;
    assign sent_inc  = r_sent + 1'b1;
    assign acc_shift = r_acc >> (r_bits - ABITS_W'(8));
    assign byte_hi   = acc_shift[7:0];
    assign byte_fill = r_acc[7:0] << (ABITS_W'(8) - r_bits);
    assign room      = TOTAL_W'(TOTAL_BITS) - r_total;
    assign term      = (room < TOTAL_W'(4)) ? room[2:0] : 3'd4;

    // Sequence appends, byte cuts and the end-of-message flush
    always_comb begin
        n_state  = r_state;
        n_acc    = r_acc;
        n_bits   = r_bits;
        n_total  = r_total;
        n_sent   = r_sent;
        n_status = r_status;
        n_fin    = r_fin;
        n_pad    = r_pad;
        o_op_pop = 1'b0;
        rq_write = 1'b0;
        rq_data  = '0;
        rq_data.status = r_status;
        rq_data.last   = (sent_inc == SENT_W'(DATA_CODEWORDS));
        unique case (r_state)
            ST_RUN: begin
                if (r_bits >= ABITS_W'(8)) begin
                    if (emit_ok) begin
                        rq_write         = room_left;
                        rq_data.codeword = byte_hi;
                        n_bits           = r_bits - ABITS_W'(8);
                    end
                end else if (r_fin) begin
                    n_acc   = r_acc << term;
                    n_bits  = r_bits + ABITS_W'(term);
                    n_total = r_total + TOTAL_W'(term);
                    n_state = ST_FLUSH;
                end else if (!i_op_empty) begin
                    o_op_pop = 1'b1;
                    n_fin    = i_op.finish;
                    if (i_op.is_begin) begin
                        n_acc    = ACC_W'(i_op.value);
                        n_bits   = ABITS_W'(i_op.nbits);
                        n_total  = TOTAL_W'(i_op.nbits);
                        n_sent   = '0;
                        n_status = i_op.raise;
                    end else begin
                        n_acc   = (r_acc << i_op.nbits) | ACC_W'(i_op.value);
                        n_bits  = r_bits + ABITS_W'(i_op.nbits);
                        n_total = r_total + TOTAL_W'(i_op.nbits);
                        if (i_op.raise > r_status) begin
                            n_status = i_op.raise;
                        end
                    end
                end
            end
            ST_FLUSH: begin
                if (r_bits >= ABITS_W'(8)) begin
                    if (emit_ok) begin
                        rq_write         = room_left;
                        rq_data.codeword = byte_hi;
                        n_bits           = r_bits - ABITS_W'(8);
                    end
                end else if (r_bits != '0) begin
                    if (emit_ok) begin
                        rq_write         = room_left;
                        rq_data.codeword = byte_fill;
                        n_bits           = '0;
                    end
                end else begin
                    n_pad   = 1'b0;
                    n_state = ST_PAD;
                end
            end
            ST_PAD: begin
                if (room_left) begin
                    if (!rq_full) begin
                        rq_write         = 1'b1;
                        rq_data.codeword = r_pad ? PAD_BYTE_B : PAD_BYTE_A;
                        n_pad            = !r_pad;
                    end
                end else begin
                    n_fin   = 1'b0;
                    n_state = ST_RUN;
                end
            end
            default: n_state = ST_RUN;
        endcase
        if (rq_write) begin
            n_sent = sent_inc;
        end
    end

    // Advance the accumulator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RUN;
            r_acc    <= '0;
            r_bits   <= '0;
            r_total  <= '0;
            r_sent   <= '0;
            r_status <= STATUS_OK;
            r_fin    <= 1'b0;
            r_pad    <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_acc    <= n_acc;
            r_bits   <= n_bits;
            r_total  <= n_total;
            r_sent   <= n_sent;
            r_status <= n_status;
            r_fin    <= n_fin;
            r_pad    <= n_pad;
        end
    end

    // Hold result items until popped
    assign rq_read = pop && (r_rq_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (rq_write) begin
            r_rq[r_rq_wp] <= rq_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rq_wp  <= 1'b0;
            r_rq_rp  <= 1'b0;
            r_rq_cnt <= 2'd0;
        end else begin
            if (rq_write) begin
                r_rq_wp <= !r_rq_wp;
            end
            if (rq_read) begin
                r_rq_rp <= !r_rq_rp;
            end
            case ({rq_write, rq_read})
                2'b10:   r_rq_cnt <= r_rq_cnt + 1'b1;
                2'b01:   r_rq_cnt <= r_rq_cnt - 1'b1;
                default: r_rq_cnt <= r_rq_cnt;
            endcase
        end
    end

    assign empty           = (r_rq_cnt == 2'd0);
    assign o_codeword      = r_rq[r_rq_rp].codeword;
    assign o_last_codeword = r_rq[r_rq_rp].last;
    assign o_status        = r_rq[r_rq_rp].status;

    assign o_stat.sent      = r_sent;
    assign o_stat.finishing = r_fin;

endmodule

// ===== hw/rtl/qr_alphanumeric_codeword_packer.sv =====
// Path: with the back end idle, the item that completes a codeword is registered in the step
// queue, then in the back-end accumulator, and its codeword in the result queue that feeds the ports.
// Throughput: one item per cycle into a 4-deep step queue while it is not full; the back end
// runs one step or one codeword per cycle, a codeword only while the result queue has room; the
// message end adds a burst of terminator, fill and padding codewords.
// Reset: synchronous, active low; clears all control state and sets mode_bits to 0010.
// ----------------------------------------------------------------------------
// qr_alphanumeric_codeword_packer
// Version 1-H alphanumeric data codeword packer: front end classifies items,
// back end packs bits and emits codewords.
// ----------------------------------------------------------------------------
`include "qr_alphanumeric_codeword_packer_assert.svh"

module qr_alphanumeric_codeword_packer
    import qrac_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic       i_cmd,
    input  logic [8:0] i_message_length,
    input  logic [7:0] i_char_code,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] o_codeword,
    output logic       o_last_codeword,
    output logic [1:0] o_status,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [3:0] i_cfg_mode_bits
);

    logic       opq_full;
    logic       opq_empty;
    logic       op_push;
    logic       op_pop;
    t_op        op_in;
    t_op        op_out;
    t_back_stat back_stat;

    qrac_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_cmd            (i_cmd),
        .i_message_length (i_message_length),
        .i_char_code      (i_char_code),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_mode_bits  (i_cfg_mode_bits),
        .i_opq_full       (opq_full),
        .o_op_push        (op_push),
        .o_op             (op_in)
    );

    qrac_op_queue u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_op    (op_in),
        .o_full  (opq_full),
        .i_pop   (op_pop),
        .o_op    (op_out),
        .o_empty (opq_empty)
    );

    qrac_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op_out),
        .i_op_empty      (opq_empty),
        .o_op_pop        (op_pop),
        .empty           (empty),
        .pop             (pop),
        .o_codeword      (o_codeword),
        .o_last_codeword (o_last_codeword),
        .o_status        (o_status),
        .o_stat          (back_stat)
    );

    // Front never pushes into a full step queue
    `QRAC_ASSERT_NOW(a_opq_no_overflow, i_clk, i_rst_n, op_push, !opq_full)
    // Back never pops an empty step queue
    `QRAC_ASSERT_NOW(a_opq_no_underflow, i_clk, i_rst_n, op_pop, !opq_empty)
    // Codeword count stays within the symbol
    `QRAC_ASSERT_NOW(a_sent_bound, i_clk, i_rst_n, 1'b1, back_stat.sent <= SENT_W'(DATA_CODEWORDS))
    // A shown result never carries the unused status code
    `QRAC_ASSERT_NOW(a_status_code, i_clk, i_rst_n, !empty, o_status != 2'd3)
    // Hold the step queue while the message end is in progress
    `QRAC_ASSERT_NOW(a_no_pop_finishing, i_clk, i_rst_n, op_pop, !back_stat.finishing)

endmodule

// ===== verif/qr_alphanumeric_codeword_packer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qr_alphanumeric_codeword_packer_tb
// Drives begin and character items into the packer and checks every popped
// codeword, last flag and status against a local bit-level model of the
// version 1-H alphanumeric stream. A short table of corner-case items runs
// first, then phases of random messages under several mode indicators, with
// random gaps on both handshakes and one long output hold-off.
// ----------------------------------------------------------------------------
module qr_alphanumeric_codeword_packer_tb;
    import qrac_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int PHASE_ITEMS   = 55;
    localparam int PHASES        = 6;
    localparam int SETTLE_CYCLES = 32;
    localparam int HOLD_CYCLES   = 300;
    localparam int SCRIPT_ROWS   = 26;

    // Symbols 36..44 of the alphanumeric set, in index order
    localparam logic [71:0] SPECIAL_CODES =
        {8'h20, 8'h24, 8'h25, 8'h2A, 8'h2B, 8'h2D, 8'h2E, 8'h2F, 8'h3A};

    // One directed item, with an optional typed first codeword
    typedef struct packed {
        logic       cmd;
        logic [8:0] len;
        logic [7:0] chr;
        logic       typed;
        logic [7:0] cw;
        logic [1:0] st;
    } t_script_row;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic       i_cmd;
    logic [8:0] i_message_length;
    logic [7:0] i_char_code;
    logic       empty;
    logic       pop;
    logic [7:0] o_codeword;
    logic       o_last_codeword;
    logic [1:0] o_status;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [3:0] i_cfg_mode_bits;

    // Local copy of the packer state
    logic [3:0]  mode_reg;
    logic [23:0] acc_bits;
    int          acc_count;
    int          bits_used;
    int          chars_left;
    int          words_sent;
    logic [5:0]  pair_first;
    bit          pair_open;
    bit          msg_open;
    logic [1:0]  msg_status;

    t_result     pending_codewords[$];
    t_result     want;
    t_script_row script [SCRIPT_ROWS];
    int          errors;
    bit          steady;
    bit          hold_req;

    qr_alphanumeric_codeword_packer u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_cmd            (i_cmd),
        .i_message_length (i_message_length),
        .i_char_code      (i_char_code),
        .empty            (empty),
        .pop              (pop),
        .o_codeword       (o_codeword),
        .o_last_codeword  (o_last_codeword),
        .o_status         (o_status),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_mode_bits  (i_cfg_mode_bits)
    );

    // Generate the clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Shift n bits into the accumulator, MSB first
    task automatic put_bits(input logic [12:0] value, input int n);
        logic [31:0] wide;
        wide      = ({8'h00, acc_bits} << n) | (value & ((32'd1 << n) - 1));
        acc_bits  = wide[23:0];
        acc_count = acc_count + n;
        bits_used = bits_used + n;
    endtask

    // Queue one codeword unless the symbol is already full
    task automatic emit_byte(input logic [7:0] b);
        t_result r;
        if (words_sent < DATA_CODEWORDS) begin
            words_sent = words_sent + 1;
            r.codeword = b;
            r.last     = (words_sent == DATA_CODEWORDS);
            r.status   = msg_status;
            pending_codewords.push_back(r);
        end
    endtask

    // Move every whole byte out of the accumulator
    task automatic drain_bytes();
        while (acc_count >= 8) begin
            acc_count = acc_count - 8;
            emit_byte(8'(acc_bits >> acc_count));
        end
        acc_bits = acc_bits & 24'((24'd1 << acc_count) - 1);
    endtask

    // Terminator, zero fill to a byte, then alternating pad bytes
    task automatic close_message();
        int room;
        int term;
        int pad;
        room = 8 * DATA_CODEWORDS - bits_used;
        term = (room < 4) ? room : 4;
        pad  = 0;
        if (term > 0) put_bits(13'd0, term);
        drain_bytes();
        if (acc_count > 0) put_bits(13'd0, 8 - acc_count);
        drain_bytes();
        while (words_sent < DATA_CODEWORDS) begin
            emit_byte(pad[0] ? PAD_BYTE_B : PAD_BYTE_A);
            pad = pad + 1;
        end
        msg_open  = 1'b0;
        pair_open = 1'b0;
    endtask

    // Advance the local model by one accepted item
    task automatic pack_item(input logic c, input logic [8:0] l, input logic [7:0] ch);
        int len;
        int idx;
        if (c == CMD_BEGIN) begin
            acc_bits   = '0;
            acc_count  = 0;
            bits_used  = 0;
            pair_first = '0;
            pair_open  = 1'b0;
            words_sent = 0;
            msg_status = STATUS_OK;
            msg_open   = 1'b1;
            len        = l;
            if (len > CHAR_CAPACITY) begin
                len        = CHAR_CAPACITY;
                msg_status = STATUS_CLAMPED;
            end
            chars_left = len;
            put_bits(13'(mode_reg), 4);
            put_bits(13'(len), 9);
            drain_bytes();
            if (chars_left == 0) close_message();
        end else if (msg_open && chars_left > 0) begin
            // Map ASCII to the 45-symbol index: digits, capitals, then specials
            idx = -1;
            if (ch >= 8'h30 && ch <= 8'h39) idx = ch - 8'h30;
            else if (ch >= 8'h41 && ch <= 8'h5A) idx = ch - 8'h37;
            else begin
                for (int k = 0; k < 9; k++) begin
                    if (SPECIAL_CODES[71 - 8 * k -: 8] == ch) idx = 36 + k;
                end
            end
            if (idx < 0) begin
                idx = 0;
                if (msg_status < STATUS_INVALID) msg_status = STATUS_INVALID;
            end
            if (pair_open) begin
                put_bits(13'(pair_first * 45 + idx), 11);
                pair_open = 1'b0;
            end else if (chars_left == 1) begin
                put_bits(13'(idx), 6);
            end else begin
                pair_first = 6'(idx);
                pair_open  = 1'b1;
            end
            chars_left = chars_left - 1;
            drain_bytes();
            if (chars_left == 0) close_message();
        end
    endtask

    // Offer one item, wait for it to be taken, then update the model
    task automatic offer(input logic c, input logic [8:0] l, input logic [7:0] ch,
                         output int produced, output t_result head);
        int base_size;
        head = '0;
        if (!steady && $urandom_range(99) < 15) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push             <= 1'b1;
        i_cmd            <= c;
        i_message_length <= l;
        i_char_code      <= ch;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        base_size = pending_codewords.size();
        pack_item(c, l, ch);
        produced = pending_codewords.size() - base_size;
        if (produced > 0) head = pending_codewords[base_size];
    endtask

    // Mostly symbols of the set, sometimes any byte
    function automatic logic [7:0] random_char();
        int         idx;
        logic [7:0] c;
        if ($urandom_range(99) < 85) begin
            idx = $urandom_range(44);
            if (idx < 10) c = 8'(8'h30 + idx);
            else if (idx < 36) c = 8'(8'h37 + idx);
            else c = SPECIAL_CODES[71 - 8 * (idx - 36) -: 8];
        end else begin
            c = 8'($urandom_range(255));
        end
        return c;
    endfunction

    // One message: begin, its characters, with cut-short and stray items now and then
    task automatic send_message(inout int done);
        int         len;
        int         n_chars;
        int         cut;
        int         produced;
        int         pick;
        t_result    head;
        pick = $urandom_range(99);
        if (pick < 70) len = $urandom_range(10, 0);
        else if (pick < 85) len = $urandom_range(511, 11);
        else len = $urandom_range(511, 0);
        n_chars = (len > CHAR_CAPACITY) ? CHAR_CAPACITY : len;
        cut     = ($urandom_range(99) < 10) ? $urandom_range(n_chars, 0) : n_chars;
        offer(CMD_BEGIN, 9'(len), 8'($urandom_range(255)), produced, head);
        done = done + 1;
        for (int k = 0; k < cut; k++) begin
            offer(CMD_CHAR, 9'($urandom_range(511)), random_char(), produced, head);
            done = done + 1;
        end
        if (cut == n_chars && $urandom_range(99) < 10) begin
            offer(CMD_CHAR, 9'($urandom_range(511)), random_char(), produced, head);
        end
    endtask

    // Hold the input, wait for every codeword, then let the back end settle
    task automatic wait_drained();
        push <= 1'b0;
        while (pending_codewords.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write the mode indicator register
    task automatic write_mode(input logic [3:0] v);
        i_cfg_valid     <= 1'b1;
        i_cfg_mode_bits <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        mode_reg = v;
        i_cfg_valid <= 1'b0;
    endtask

    // Pop side: random stalls, a quiet stretch, and one long hold-off
    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                pop <= steady || ($urandom_range(99) >= 15);
            end
        end
    end

    // Compare each popped item with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_codewords.size() == 0) begin
                errors++;
                $display("%0t: unexpected codeword %h last %b status %0d", $time,
                         o_codeword, o_last_codeword, o_status);
            end else begin
                want = pending_codewords.pop_front();
                if (o_codeword !== want.codeword) begin
                    errors++;
                    $display("%0t: codeword expected %h actual %h", $time,
                             want.codeword, o_codeword);
                end
                if (o_last_codeword !== want.last) begin
                    errors++;
                    $display("%0t: last_codeword expected %b actual %b", $time,
                             want.last, o_last_codeword);
                end
                if (o_status !== want.status) begin
                    errors++;
                    $display("%0t: status expected %0d actual %0d", $time,
                             want.status, o_status);
                end
            end
        end
    end

    // Stop a hung run
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("qr_alphanumeric_codeword_packer_tb: errors");
        $finish;
    end

    // Main sequence
    initial begin
        int         produced;
        t_result    head;
        int         done;
        logic [3:0] mode_val;

        errors     = 0;
        steady     = 1'b0;
        hold_req   = 1'b0;
        mode_reg   = MODE_RESET;
        acc_bits   = '0;
        acc_count  = 0;
        bits_used  = 0;
        chars_left = 0;
        words_sent = 0;
        pair_first = '0;
        pair_open  = 1'b0;
        msg_open   = 1'b0;
        msg_status = STATUS_OK;

        i_rst_n          <= 1'b0;
        push             <= 1'b0;
        i_cmd            <= CMD_BEGIN;
        i_message_length <= '0;
        i_char_code      <= '0;
        i_cfg_valid      <= 1'b0;
        i_cfg_mode_bits  <= '0;

        // Corner items; typed first codewords assume the reset mode 0010
        script = '{
            '{CMD_BEGIN, 9'd0,   8'h00, 1'b1, 8'h20, STATUS_OK},      // zero length
            '{CMD_BEGIN, 9'd511, 8'hFF, 1'b1, 8'h20, STATUS_CLAMPED}, // clamp to capacity
            '{CMD_CHAR,  9'd511, 8'h00, 1'b0, 8'h00, STATUS_OK},      // lowest byte, invalid
            '{CMD_CHAR,  9'd0,   8'hFF, 1'b0, 8'h00, STATUS_OK},      // highest byte, invalid
            '{CMD_CHAR,  9'd0,   8'h30, 1'b0, 8'h00, STATUS_OK},      // '0'
            '{CMD_CHAR,  9'd0,   8'h5A, 1'b0, 8'h00, STATUS_OK},      // 'Z'
            '{CMD_CHAR,  9'd0,   8'h3A, 1'b0, 8'h00, STATUS_OK},      // ':'
            '{CMD_CHAR,  9'd0,   8'h20, 1'b0, 8'h00, STATUS_OK},      // space
            '{CMD_CHAR,  9'd0,   8'h61, 1'b0, 8'h00, STATUS_OK},      // lowercase, invalid
            '{CMD_CHAR,  9'd0,   8'h39, 1'b0, 8'h00, STATUS_OK},      // '9'
            '{CMD_CHAR,  9'd0,   8'h41, 1'b0, 8'h00, STATUS_OK},      // 'A'
            '{CMD_CHAR,  9'd0,   8'h24, 1'b0, 8'h00, STATUS_OK},      // '$'
            '{CMD_BEGIN, 9'd10,  8'h00, 1'b1, 8'h20, STATUS_OK},      // exactly full
            '{CMD_CHAR,  9'd0,   8'h25, 1'b0, 8'h00, STATUS_OK},      // '%'
            '{CMD_CHAR,  9'd0,   8'h2A, 1'b0, 8'h00, STATUS_OK},      // '*'
            '{CMD_CHAR,  9'd0,   8'h2B, 1'b0, 8'h00, STATUS_OK},      // '+'
            '{CMD_CHAR,  9'd0,   8'h2D, 1'b0, 8'h00, STATUS_OK},      // '-'
            '{CMD_CHAR,  9'd0,   8'h2E, 1'b0, 8'h00, STATUS_OK},      // '.'
            '{CMD_CHAR,  9'd0,   8'h2F, 1'b0, 8'h00, STATUS_OK},      // '/'
            '{CMD_BEGIN, 9'd3,   8'h00, 1'b1, 8'h20, STATUS_OK},      // drop active message
            '{CMD_CHAR,  9'd0,   8'h41, 1'b0, 8'h00, STATUS_OK},
            '{CMD_CHAR,  9'd0,   8'h42, 1'b0, 8'h00, STATUS_OK},
            '{CMD_CHAR,  9'd0,   8'h43, 1'b0, 8'h00, STATUS_OK},      // odd final char
            '{CMD_CHAR,  9'd0,   8'h58, 1'b0, 8'h00, STATUS_OK},      // no message, ignored
            '{CMD_BEGIN, 9'd1,   8'h00, 1'b1, 8'h20, STATUS_OK},
            '{CMD_CHAR,  9'd0,   8'h80, 1'b1, 8'h08, STATUS_INVALID}  // invalid single
        };

        // Hold reset, then release it
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table
        for (int k = 0; k < SCRIPT_ROWS; k++) begin
            offer(script[k].cmd, script[k].len, script[k].chr, produced, head);
            if (script[k].typed && (produced == 0 || head.codeword != script[k].cw ||
                                    head.status != script[k].st)) begin
                errors++;
                $display("%0t: row %0d first codeword expected %h/%0d actual %h/%0d",
                         $time, k, script[k].cw, script[k].st, head.codeword, head.status);
            end
        end

        // Random phases under different mode indicators
        for (int ph = 0; ph < PHASES; ph++) begin
            wait_drained();
            case (ph)
                0:       mode_val = 4'd0;
                1:       mode_val = 4'd15;
                3:       mode_val = MODE_RESET;
                default: mode_val = 4'($urandom_range(15));
            endcase
            write_mode(mode_val);
            steady = (ph == 3);
            if (ph == 1) hold_req = 1'b1;
            done = 0;
            while (done < PHASE_ITEMS) send_message(done);
        end

        wait_drained();
        if (errors == 0) begin
            $display("qr_alphanumeric_codeword_packer_tb: clean");
        end else begin
            $display("qr_alphanumeric_codeword_packer_tb: errors");
        end
        $finish;
    end

endmodule

// ===== qr_alphanumeric_codeword_packer.f =====
+incdir+hw/rtl
hw/rtl/qrac_pkg.sv
hw/rtl/qrac_front.sv
hw/rtl/qrac_op_queue.sv
hw/rtl/qrac_back.sv
hw/rtl/qr_alphanumeric_codeword_packer.sv
verif/qr_alphanumeric_codeword_packer_tb.sv
